// ===== rtl/rlecpd_pkg.sv =====
// rlecpd_pkg: shared types, constants and helper functions of the run-length
// cell pattern decoder
// no dependencies
package rlecpd_pkg;

    // widths
    localparam int COUNT_BITS = 16;
    localparam int CoordW     = 32;
    localparam int LenW       = 16;
    localparam int CharW      = 8;
    localparam int WeightW    = 2;
    localparam int RegIdxW    = 3;
    localparam int AddrW      = 5;
    localparam int OutDataW   = 2 * CoordW + LenW;

    // character codes of the pattern text
    localparam logic [CharW-1:0] CharLf     = 8'h0a;
    localparam logic [CharW-1:0] CharTab    = 8'h09;
    localparam logic [CharW-1:0] CharSpace  = 8'h20;
    localparam logic [CharW-1:0] CharZero   = 8'h30;
    localparam logic [CharW-1:0] CharNine   = 8'h39;
    localparam logic [CharW-1:0] CharLive   = 8'h6f;  // 'o'
    localparam logic [CharW-1:0] CharDead   = 8'h62;  // 'b'
    localparam logic [CharW-1:0] CharRowEnd = 8'h24;  // '$'

    // register indexes on the configuration port
    localparam logic [RegIdxW-1:0] RegOriginX = 3'd0;
    localparam logic [RegIdxW-1:0] RegOriginY = 3'd1;
    localparam logic [RegIdxW-1:0] RegXx      = 3'd2;
    localparam logic [RegIdxW-1:0] RegXy      = 3'd3;
    localparam logic [RegIdxW-1:0] RegYx      = 3'd4;
    localparam logic [RegIdxW-1:0] RegYy      = 3'd5;

    // weight codes
    localparam logic [WeightW-1:0] WZero   = 2'b00;
    localparam logic [WeightW-1:0] WOne    = 2'b01;
    localparam logic [WeightW-1:0] WMinTwo = 2'b10;
    localparam logic [WeightW-1:0] WMinOne = 2'b11;

    typedef struct packed {
        logic [CoordW-1:0]     col;
        logic [CoordW-1:0]     row;
        logic [COUNT_BITS-1:0] count;
        logic                  skip;
    } t_state;

    typedef struct packed {
        logic [CoordW-1:0]  origin_x;
        logic [CoordW-1:0]  origin_y;
        logic [WeightW-1:0] xx;
        logic [WeightW-1:0] xy;
        logic [WeightW-1:0] yx;
        logic [WeightW-1:0] yy;
    } t_cfg;

    typedef struct packed {
        logic [LenW-1:0]   len;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] x;
    } t_run;

    // weight in -2..1 times a coordinate, modulo 2^32
    function automatic logic [CoordW-1:0] wmul(input logic [WeightW-1:0] w,
                                               input logic [CoordW-1:0] v);
        logic [CoordW-1:0] res;
        unique case (w)
            WZero:   res = '0;
            WOne:    res = v;
            WMinOne: res = '0 - v;
            WMinTwo: res = '0 - {v[CoordW-2:0], 1'b0};
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/rlecpd_step.sv =====
// rlecpd_step: next state and run result for one pattern character
// depends on rlecpd_pkg
module rlecpd_step (
    input  rlecpd_pkg::t_state                   i_state,
    input  rlecpd_pkg::t_cfg                     i_cfg,
    input  logic                                 i_restart,
    input  logic [rlecpd_pkg::CharW-1:0]         i_char,
    output rlecpd_pkg::t_state                   o_state,
    output logic                                 o_emit,
    output rlecpd_pkg::t_run                     o_run
);
    localparam int CW = rlecpd_pkg::COUNT_BITS;
    localparam int VW = CW + 4;
    localparam logic [CW-1:0] CountMax = '1;

    rlecpd_pkg::t_state s0;
    logic [CW-1:0]  cnt_n;
    logic [rlecpd_pkg::CoordW-1:0] step_n;
    logic [VW-1:0]  dec_v;
    logic [CW-1:0]  dec_sat;
    logic           is_digit;

    // restart clears the state before the character
    always_comb begin
        if (i_restart) begin
            s0 = '0;
        end else begin
            s0 = i_state;
        end
    end

    // count, where zero means one
    assign cnt_n  = (s0.count == '0) ? CW'(1) : s0.count;
    assign step_n = rlecpd_pkg::CoordW'(cnt_n);

    // decimal accumulate with saturation
    assign dec_v = (VW'(s0.count) << 3) + (VW'(s0.count) << 1)
                 + VW'(i_char - rlecpd_pkg::CharZero);
    assign dec_sat = (dec_v > VW'(CountMax)) ? CountMax : dec_v[CW-1:0];
    assign is_digit = (i_char >= rlecpd_pkg::CharZero) && (i_char <= rlecpd_pkg::CharNine);

    // run start through the transform
    assign o_run.x = i_cfg.origin_x + rlecpd_pkg::wmul(i_cfg.xx, s0.col)
                   + rlecpd_pkg::wmul(i_cfg.xy, s0.row);
    assign o_run.y = i_cfg.origin_y + rlecpd_pkg::wmul(i_cfg.yx, s0.col)
                   + rlecpd_pkg::wmul(i_cfg.yy, s0.row);
    assign o_run.len = (step_n > rlecpd_pkg::CoordW'(16'hffff)) ? 16'hffff
                                                               : step_n[rlecpd_pkg::LenW-1:0];

    // character decode
    always_comb begin
        o_state = s0;
        o_emit  = 1'b0;
        priority if (i_char == rlecpd_pkg::CharLf) begin
            o_state.row   = s0.row + rlecpd_pkg::CoordW'(s0.skip);
            o_state.skip  = 1'b0;
            o_state.count = '0;
        end else if (s0.skip) begin
            o_state = s0;
        end else if (is_digit) begin
            o_state.count = dec_sat;
        end else if (i_char == rlecpd_pkg::CharSpace || i_char == rlecpd_pkg::CharTab) begin
            o_state = s0;
        end else if (i_char == rlecpd_pkg::CharDead) begin
            o_state.col   = s0.col + step_n;
            o_state.count = '0;
        end else if (i_char == rlecpd_pkg::CharRowEnd) begin
            o_state.row   = s0.row + step_n;
            o_state.col   = '0;
            o_state.count = '0;
        end else if (i_char == rlecpd_pkg::CharLive) begin
            o_emit        = 1'b1;
            o_state.col   = s0.col + step_n;
            o_state.count = '0;
        end else begin
            // bang or unknown character: ignore rest of line
            o_state.skip = 1'b1;
        end
    end

endmodule

// ===== rtl/rle_cell_pattern_decoder.sv =====
// rle_cell_pattern_decoder: top level with stream ports, configuration
// registers, input register and result register
// depends on rlecpd_pkg and rlecpd_step
//
// Takes one pattern character per transaction and returns one run per 'o'
// outside a line that is being skipped. A character is registered on input,
// and its run is loaded into the result register once the result side can
// take it; the run is then offered on the result port from that register. A
// new character can be taken every cycle while the result side keeps up; the
// single update of column, row and count per cycle sets this rate. The user
// must write configuration through the APB port only while the block is idle;
// the block itself does not enforce this.
module rle_cell_pattern_decoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // char_code
    input  logic                                 s_axis_tuser,  // restart
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rlecpd_pkg::OutDataW-1:0]      m_axis_tdata,  // run_x, run_y, run_length
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rlecpd_pkg::AddrW-1:0]         paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    rlecpd_pkg::t_cfg   r_cfg;
    rlecpd_pkg::t_state r_state;
    rlecpd_pkg::t_state n_state;
    rlecpd_pkg::t_run   n_run;
    rlecpd_pkg::t_run   r_run;
    logic               r_in_valid;
    logic               r_in_restart;
    logic [7:0]         r_in_char;
    logic               r_out_valid;
    logic               emit;
    logic               out_ready;
    logic               proc;
    logic               cfg_wr;
    logic [rlecpd_pkg::RegIdxW-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rlecpd_pkg::AddrW-1:2];
    assign cfg_wr  = psel & penable & pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.xx       <= rlecpd_pkg::WOne;
            r_cfg.xy       <= rlecpd_pkg::WZero;
            r_cfg.yx       <= rlecpd_pkg::WZero;
            r_cfg.yy       <= rlecpd_pkg::WOne;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                rlecpd_pkg::RegOriginX: r_cfg.origin_x <= pwdata;
                rlecpd_pkg::RegOriginY: r_cfg.origin_y <= pwdata;
                rlecpd_pkg::RegXx:      r_cfg.xx       <= pwdata[1:0];
                rlecpd_pkg::RegXy:      r_cfg.xy       <= pwdata[1:0];
                rlecpd_pkg::RegYx:      r_cfg.yx       <= pwdata[1:0];
                rlecpd_pkg::RegYy:      r_cfg.yy       <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_idx)
            rlecpd_pkg::RegOriginX: prdata = r_cfg.origin_x;
            rlecpd_pkg::RegOriginY: prdata = r_cfg.origin_y;
            rlecpd_pkg::RegXx:      prdata = {30'd0, r_cfg.xx};
            rlecpd_pkg::RegXy:      prdata = {30'd0, r_cfg.xy};
            rlecpd_pkg::RegYx:      prdata = {30'd0, r_cfg.yx};
            rlecpd_pkg::RegYy:      prdata = {30'd0, r_cfg.yy};
            default:                prdata = '0;
        endcase
    end

    // pipeline flow
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char    <= s_axis_tdata;
            r_in_restart <= s_axis_tuser;
        end
    end

    rlecpd_step u_step (
        .i_state   (r_state),
        .i_cfg     (r_cfg),
        .i_restart (r_in_restart),
        .i_char    (r_in_char),
        .o_state   (n_state),
        .o_emit    (emit),
        .o_run     (n_run)
    );

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= proc && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_run <= n_run;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_run;

endmodule

// ===== rtl/rlecpd_checker.sv =====
// rlecpd_checker: port-level assertions for the pattern decoder, bound to
// the top level
// depends on rlecpd_pkg and rle_cell_pattern_decoder
module rlecpd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rlecpd_pkg::OutDataW-1:0]  m_axis_tdata
);
    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a run always has at least one cell
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[rlecpd_pkg::OutDataW-1:2*rlecpd_pkg::CoordW] != '0)
        else $error("run length zero");

    // a fresh result follows a character taken earlier on the input port
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a character");

endmodule

bind rle_cell_pattern_decoder rlecpd_checker u_rlecpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
